// ===== hdl/blpg_pkg.sv =====
// Shared types and constants of the line pixel generator.
package blpg_pkg;

   // Input command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Register indexes, taken from csr_paddr[3:2]
   localparam logic [1:0] REG_X_PAN       = 2'd0;
   localparam logic [1:0] REG_Y_PAN       = 2'd1;
   localparam logic [1:0] REG_PIXEL_BYTES = 2'd2;
   localparam logic [1:0] REG_ROW_STRIDE  = 2'd3;

   // Register reset values
   localparam logic [11:0] X_PAN_RESET       = 12'd0;
   localparam logic [11:0] Y_PAN_RESET       = 12'd0;
   localparam logic [3:0]  PIXEL_BYTES_RESET = 4'd4;
   localparam logic [15:0] ROW_STRIDE_RESET  = 16'd8192;

   // Field widths
   localparam int IN_BITS   = 11;
   localparam int OUT_BITS  = 12;
   localparam int ADDR_BITS = 30;
   localparam int ERR_BITS  = 14;

   typedef struct packed {
      logic [11:0] x_pan;
      logic [11:0] y_pan;
      logic [3:0]  pixel_bytes;
      logic [15:0] row_stride;
   } cfg_type;

   // Status of the stepper's pixel register and line state
   typedef struct packed {
      logic pix_valid;
      logic pix_last;
      logic line_active;
   } stp_status_type;

endpackage

// ===== hdl/blpg_csr.sv =====
// Configuration register file with APB-style access.
module blpg_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output blpg_pkg::cfg_type    cfg
);

   blpg_pkg::cfg_type cfg_ff;
   blpg_pkg::cfg_type cfg_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            blpg_pkg::REG_X_PAN:       cfg_in.x_pan       = csr_pwdata[11:0];
            blpg_pkg::REG_Y_PAN:       cfg_in.y_pan       = csr_pwdata[11:0];
            blpg_pkg::REG_PIXEL_BYTES: cfg_in.pixel_bytes = csr_pwdata[3:0];
            blpg_pkg::REG_ROW_STRIDE:  cfg_in.row_stride  = csr_pwdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_pan       <= blpg_pkg::X_PAN_RESET;
         cfg_ff.y_pan       <= blpg_pkg::Y_PAN_RESET;
         cfg_ff.pixel_bytes <= blpg_pkg::PIXEL_BYTES_RESET;
         cfg_ff.row_stride  <= blpg_pkg::ROW_STRIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (csr_paddr[3:2])
         blpg_pkg::REG_X_PAN:       csr_prdata = {20'd0, cfg_ff.x_pan};
         blpg_pkg::REG_Y_PAN:       csr_prdata = {20'd0, cfg_ff.y_pan};
         blpg_pkg::REG_PIXEL_BYTES: csr_prdata = {28'd0, cfg_ff.pixel_bytes};
         blpg_pkg::REG_ROW_STRIDE:  csr_prdata = {16'd0, cfg_ff.row_stride};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/blpg_stepper.sv =====
// Line state, per-command step logic and the pixel register.
module blpg_stepper #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_fire,
   input  logic                         in_command,
   input  logic [blpg_pkg::IN_BITS-1:0] x_start,
   input  logic [blpg_pkg::IN_BITS-1:0] y_start,
   input  logic [blpg_pkg::IN_BITS-1:0] x_end,
   input  logic [blpg_pkg::IN_BITS-1:0] y_end,
   input  logic [blpg_pkg::IN_BITS-1:0] shift_x,
   input  logic [blpg_pkg::IN_BITS-1:0] shift_y,
   input  logic                         pix_take,
   output logic [COORD_BITS-1:0]        pix_x,
   output logic [COORD_BITS-1:0]        pix_y,
   output blpg_pkg::stp_status_type     status
);

   localparam int IW = blpg_pkg::IN_BITS;
   localparam int EW = blpg_pkg::ERR_BITS;
   localparam int SW = (COORD_BITS > IW + 1) ? COORD_BITS : IW + 1;

   // Line state
   logic                  active_ff, active_in;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [IW-1:0]         delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic                  x_back_ff, x_back_in, y_back_ff, y_back_in;
   logic signed [EW-1:0]  err_ff, err_in;

   // Pixel register
   logic                  pix_valid_ff, pix_valid_in;
   logic                  pix_last_ff, pix_last_in;
   logic [COORD_BITS-1:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;

   // Load setup
   logic [IW-1:0]        load_dx, load_dy;
   logic [SW-1:0]        sum_xa, sum_ya, sum_xb, sum_yb;
   logic signed [EW-1:0] load_err;

   // Step logic
   logic                  emit, at_goal, go_x, go_y;
   logic signed [EW-1:0]  dx_s, dy_s, err_step;
   logic [COORD_BITS-1:0] cur_x_step, cur_y_step;

   always_comb begin
      load_dx = (x_end > x_start) ? x_end - x_start : x_start - x_end;
      load_dy = (y_end > y_start) ? y_end - y_start : y_start - y_end;
      sum_xa  = SW'(x_start) + SW'(shift_x);
      sum_ya  = SW'(y_start) + SW'(shift_y);
      sum_xb  = SW'(x_end) + SW'(shift_x);
      sum_yb  = SW'(y_end) + SW'(shift_y);
      // halve the leading delta, truncating toward zero
      load_err = (load_dx > load_dy) ? $signed(EW'(load_dx >> 1))
                                     : -$signed(EW'(load_dy >> 1));
   end

   always_comb begin
      at_goal    = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);
      dx_s       = $signed(EW'(delta_x_ff));
      dy_s       = $signed(EW'(delta_y_ff));
      go_x       = err_ff > -dx_s;
      go_y       = err_ff < dy_s;
      err_step   = err_ff - (go_x ? dy_s : EW'(0)) + (go_y ? dx_s : EW'(0));
      cur_x_step = x_back_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
      cur_y_step = y_back_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
      emit       = in_fire && (in_command == blpg_pkg::CMD_STEP) && active_ff;
   end

   // Next state
   always_comb begin
      active_in    = active_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      delta_x_in   = delta_x_ff;
      delta_y_in   = delta_y_ff;
      x_back_in    = x_back_ff;
      y_back_in    = y_back_ff;
      err_in       = err_ff;
      pix_valid_in = pix_valid_ff && !pix_take;
      pix_last_in  = pix_last_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      if (in_fire && (in_command == blpg_pkg::CMD_LOAD)) begin
         // replace any line in progress
         active_in  = 1'b1;
         cur_x_in   = sum_xa[COORD_BITS-1:0];
         cur_y_in   = sum_ya[COORD_BITS-1:0];
         goal_x_in  = sum_xb[COORD_BITS-1:0];
         goal_y_in  = sum_yb[COORD_BITS-1:0];
         delta_x_in = load_dx;
         delta_y_in = load_dy;
         x_back_in  = !(x_start < x_end);
         y_back_in  = !(y_start < y_end);
         err_in     = load_err;
      end else if (emit) begin
         // hand the current pixel over and advance
         pix_valid_in = 1'b1;
         pix_last_in  = at_goal;
         pix_x_in     = cur_x_ff;
         pix_y_in     = cur_y_ff;
         if (at_goal) begin
            active_in = 1'b0;
         end else begin
            err_in = err_step;
            if (go_x) begin
               cur_x_in = cur_x_step;
            end
            if (go_y) begin
               cur_y_in = cur_y_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         delta_x_ff   <= '0;
         delta_y_ff   <= '0;
         x_back_ff    <= 1'b0;
         y_back_ff    <= 1'b0;
         err_ff       <= '0;
         pix_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         delta_x_ff   <= delta_x_in;
         delta_y_ff   <= delta_y_in;
         x_back_ff    <= x_back_in;
         y_back_ff    <= y_back_in;
         err_ff       <= err_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   // Pixel payload, no reset
   always_ff @(posedge clock) begin
      pix_last_ff <= pix_last_in;
      pix_x_ff    <= pix_x_in;
      pix_y_ff    <= pix_y_in;
   end

   assign pix_x              = pix_x_ff;
   assign pix_y              = pix_y_ff;
   assign status.pix_valid   = pix_valid_ff;
   assign status.pix_last    = pix_last_ff;
   assign status.line_active = active_ff;

endmodule

// ===== hdl/blpg_addr.sv =====
// Framebuffer address computation and the result register.
module blpg_addr #(
   parameter int COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [COORD_BITS-1:0]          pix_x,
   input  logic [COORD_BITS-1:0]          pix_y,
   input  blpg_pkg::stp_status_type       status,
   input  blpg_pkg::cfg_type              cfg,
   output logic                           pix_take,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [blpg_pkg::OUT_BITS-1:0]  rsp_pixel_x,
   output logic [blpg_pkg::OUT_BITS-1:0]  rsp_pixel_y,
   output logic [blpg_pkg::ADDR_BITS-1:0] rsp_pixel_address,
   output logic                           rsp_last_pixel
);

   localparam int OW   = blpg_pkg::OUT_BITS;
   localparam int AB   = blpg_pkg::ADDR_BITS;
   localparam int CW   = (COORD_BITS > OW) ? COORD_BITS : OW;
   localparam int PANW = CW + 1;
   localparam int XPW  = PANW + 4;
   localparam int YPW  = PANW + 16;
   localparam int SUMW = (YPW + 1 > AB) ? YPW + 1 : AB;

   logic            rsp_valid_ff, rsp_valid_in, load;
   logic [OW-1:0]   px_ff, px_in, py_ff, py_in;
   logic [AB-1:0]   addr_ff, addr_in;
   logic            last_ff;
   logic [CW-1:0]   x_wide, y_wide;
   logic [PANW-1:0] x_pan_sum, y_pan_sum;
   logic [XPW-1:0]  x_prod;
   logic [YPW-1:0]  y_prod;
   logic [SUMW-1:0] addr_sum;

   assign pix_take = !rsp_valid_ff || rsp_ready;
   assign load     = status.pix_valid && pix_take;

   // Offset, scale and add the two axes
   always_comb begin
      x_wide    = CW'(pix_x);
      y_wide    = CW'(pix_y);
      x_pan_sum = PANW'(x_wide) + PANW'(cfg.x_pan);
      y_pan_sum = PANW'(y_wide) + PANW'(cfg.y_pan);
      x_prod    = XPW'(x_pan_sum) * XPW'(cfg.pixel_bytes);
      y_prod    = YPW'(y_pan_sum) * YPW'(cfg.row_stride);
      addr_sum  = SUMW'(x_prod) + SUMW'(y_prod);
      addr_in   = addr_sum[AB-1:0];
      px_in     = x_wide[OW-1:0];
      py_in     = y_wide[OW-1:0];
   end

   // Hold while the receiver stalls, drop once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         addr_ff <= addr_in;
         last_ff <= status.pix_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = px_ff;
   assign rsp_pixel_y       = py_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_last_pixel    = last_ff;

endmodule

// ===== hdl/bresenham_line_pixel_generator_unit.sv =====
// Top level of the Bresenham line pixel generator.
//
// Input channel (req_*): a load command (req_command = 0) takes two endpoints
// and a shift and starts a new line, replacing any line in progress; it gives
// no result. A step command (req_command = 1) gives the next pixel of the
// line, starting at the first endpoint; a step with no line active gives
// nothing. After the pixel flagged rsp_last_pixel the line is finished.
// Result channel (rsp_*): pixel coordinates, framebuffer byte address
// (x + x_pan) * pixel_bytes + (y + y_pan) * row_stride modulo 2^30, and the
// last flag. After its step transfer, a result passes through the stepper's
// pixel register and then the address multipliers' result register.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single stepper register stage and the output register.
// When the receiver stalls, the result register holds and one more pixel
// waits in the pixel register; req_ready then drops until the output drains.
// Reset clears the line (no line active) and loads the register defaults.
// Configuration (csr_*): x_pan at 0x0, y_pan at 0x4, pixel_bytes at 0x8,
// row_stride at 0xC; write only while the block is idle.
module bresenham_line_pixel_generator_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [blpg_pkg::IN_BITS-1:0]   req_x_start,
   input  logic [blpg_pkg::IN_BITS-1:0]   req_y_start,
   input  logic [blpg_pkg::IN_BITS-1:0]   req_x_end,
   input  logic [blpg_pkg::IN_BITS-1:0]   req_y_end,
   input  logic [blpg_pkg::IN_BITS-1:0]   req_shift_x,
   input  logic [blpg_pkg::IN_BITS-1:0]   req_shift_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [blpg_pkg::OUT_BITS-1:0]  rsp_pixel_x,
   output logic [blpg_pkg::OUT_BITS-1:0]  rsp_pixel_y,
   output logic [blpg_pkg::ADDR_BITS-1:0] rsp_pixel_address,
   output logic                           rsp_last_pixel,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [3:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   blpg_pkg::cfg_type        cfg;
   blpg_pkg::stp_status_type stp_status;
   logic [COORD_BITS-1:0]    pix_x, pix_y;
   logic                     pix_take, req_fire;

   // Accept while the pixel register is empty or moving on
   assign req_ready = !stp_status.pix_valid || pix_take;
   assign req_fire  = req_valid && req_ready;

   blpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   blpg_stepper #(
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (req_fire),
      .in_command (req_command),
      .x_start    (req_x_start),
      .y_start    (req_y_start),
      .x_end      (req_x_end),
      .y_end      (req_y_end),
      .shift_x    (req_shift_x),
      .shift_y    (req_shift_y),
      .pix_take   (pix_take),
      .pix_x      (pix_x),
      .pix_y      (pix_y),
      .status     (stp_status)
   );

   blpg_addr #(
      .COORD_BITS (COORD_BITS)
   ) u_addr (
      .clock             (clock),
      .reset             (reset),
      .pix_x             (pix_x),
      .pix_y             (pix_y),
      .status            (stp_status),
      .cfg               (cfg),
      .pix_take          (pix_take),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_last_pixel    (rsp_last_pixel)
   );

   // A pixel moving out of the pixel register shows up as a result
   a_pix_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (stp_status.pix_valid && pix_take) |=> rsp_valid)
      else $error("pixel transfer did not reach the result register");

   // A load, or a step with no line active, yields no pixel
   a_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_command == blpg_pkg::CMD_LOAD || !stp_status.line_active))
      |=> !stp_status.pix_valid)
      else $error("pixel produced without an active line step");

   // A load starts a line
   a_load_active: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == blpg_pkg::CMD_LOAD) |=> stp_status.line_active)
      else $error("load did not start a line");

   // The last pixel of a line ends it
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      ($rose(stp_status.pix_valid) && stp_status.pix_last
       && !$past(req_fire && req_command == blpg_pkg::CMD_LOAD))
      |-> !stp_status.line_active)
      else $error("line still active after its last pixel");

endmodule
